@@ design/lpi_pkg.sv @@
// lpi_pkg: shared types, constants and arithmetic helpers for the leapfrog integrator
// used by lpi_front, lpi_back, the top level, the checker and the dv benches; no dependencies

package lpi_pkg;

    localparam int ID_W       = 10;
    localparam int FIX_W      = 32;
    localparam int DT_W       = 24;
    localparam int PROD_W     = FIX_W + DT_W + 1;
    localparam int RND_W      = FIX_W + 1;
    localparam int SUM_W      = FIX_W + 2;
    localparam int MOD_W      = ID_W + 17;
    localparam int KICK_SH    = 25;
    localparam int DRIFT_SH   = 24;
    localparam int FOLD_SPLIT = 5;

    localparam logic [DT_W-1:0] DT_RESET = 24'd16777;

    typedef logic signed [FIX_W-1:0] fix_t;

    typedef struct packed {
        logic [ID_W-1:0] body_id;
        logic            is_dynamic;
        fix_t            vel_x;
        fix_t            vel_y;
        fix_t            vel_z;
        fix_t            acc_x;
        fix_t            acc_y;
        fix_t            acc_z;
        fix_t            pos_x;
        fix_t            pos_y;
        fix_t            pos_z;
    } in_item_t;

    typedef struct packed {
        fix_t new_vel_x;
        fix_t new_vel_y;
        fix_t new_vel_z;
        fix_t new_pos_x;
        fix_t new_pos_y;
        fix_t new_pos_z;
    } out_item_t;

    // queued work item, axis 0 is x
    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic                  dyn;
        logic [2:0][FIX_W-1:0] vel;
        logic [2:0][FIX_W-1:0] acc;
        logic [2:0][FIX_W-1:0] pos;
    } work_t;

    // back end to front end control
    typedef struct packed {
        logic take;
        logic clearing;
    } bk_ctl_t;

    // restoring remainder steps for shifts hi down to lo
    function automatic logic [ID_W-1:0] id_fold(logic [ID_W-1:0] v, logic [MOD_W-1:0] m,
                                                int hi, int lo);
        logic [MOD_W-1:0] r;
        r = MOD_W'(v);
        for (int k = ID_W - 1; k >= 0; k--) begin
            if (k <= hi && k >= lo && r >= (m << k)) begin
                r = r - (m << k);
            end
        end
        return r[ID_W-1:0];
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic logic signed [RND_W-1:0] round_shift(logic signed [PROD_W-1:0] p,
                                                            int sh);
        logic signed [PROD_W-1:0] t;
        t = p + $signed(PROD_W'(1) << (sh - 1));
        return RND_W'(t >>> sh);
    endfunction

    function automatic fix_t sat_fix(logic signed [SUM_W-1:0] v);
        if ((&v[SUM_W-1:FIX_W-1]) || !(|v[SUM_W-1:FIX_W-1])) begin
            return fix_t'(v[FIX_W-1:0]);
        end
        return v[SUM_W-1] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
    endfunction

endpackage

@@ design/lpi_front.sv @@
// lpi_front: accepts body items, classifies them and holds them in a two-entry queue
// depends on lpi_pkg

module lpi_front
    import lpi_pkg::*;
#(
    parameter int MAX_BODIES = 1024
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t body,
    input  bk_ctl_t  ctl,
    output logic     head_valid,
    output work_t    head
);

    localparam int               QDEPTH   = 2;
    localparam logic [MOD_W-1:0] BODY_CNT = MOD_W'(MAX_BODIES);

    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    work_t      ent_reg [QDEPTH];
    work_t      cls;
    logic       accept;

    // upper remainder steps here, the rest in the back end
    always_comb
    begin
        cls.id  = id_fold(body.body_id, BODY_CNT, ID_W - 1, FOLD_SPLIT);
        cls.dyn = body.is_dynamic;
        cls.vel = {body.vel_z, body.vel_y, body.vel_x};
        cls.acc = {body.acc_z, body.acc_y, body.acc_x};
        cls.pos = {body.pos_z, body.pos_y, body.pos_x};
    end

    assign full       = (cnt_reg == 2'(QDEPTH)) || ctl.clearing;
    assign accept     = push && !full;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next    = cnt_reg + 2'(accept) - 2'(ctl.take);
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = ctl.take ? !rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ design/lpi_back.sv @@
// lpi_back: sequencer that integrates one queued item at a time, owns the body state
// memories and the result register; depends on lpi_pkg

module lpi_back
    import lpi_pkg::*;
#(
    parameter int MAX_BODIES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [DT_W-1:0] time_step,
    input  logic            head_valid,
    input  work_t           head,
    output bk_ctl_t         ctl,
    input  logic            pop,
    output logic            empty,
    output out_item_t       result
);

    localparam int               DEPTH    = (MAX_BODIES < (2 ** ID_W)) ? MAX_BODIES : (2 ** ID_W);
    localparam int               IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [MOD_W-1:0] BODY_CNT = MOD_W'(MAX_BODIES);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MUL_K = 4'd2;
    localparam logic [3:0] ST_RND_K = 4'd3;
    localparam logic [3:0] ST_VEL   = 4'd4;
    localparam logic [3:0] ST_HALF  = 4'd5;
    localparam logic [3:0] ST_MUL_D = 4'd6;
    localparam logic [3:0] ST_RND_D = 4'd7;
    localparam logic [3:0] ST_POS   = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                   res_valid_reg, res_valid_next;
    out_item_t              res_reg;
    work_t                  work_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_in;
    logic [3*FIX_W-1:0]     hv_rd_reg;
    logic                   vis_rd_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [RND_W-1:0]  rnd_reg  [3];
    fix_t                   nv_reg [3];
    fix_t                   hv_reg [3];
    fix_t                   np [3];
    logic [3*FIX_W-1:0]     hv_mem [DEPTH];
    logic                   vis_mem [DEPTH];
    logic                   take;
    logic                   clearing;
    logic                   res_hold;
    logic                   hv_we;
    logic                   vis_we;
    logic [IDX_W-1:0]       vis_addr;
    logic signed [DT_W:0]   dt_s;

    assign clearing = (state_reg == ST_CLEAR);
    assign take     = (state_reg == ST_IDLE) && head_valid;
    assign res_hold = res_valid_reg && !pop;
    assign idx_in   = IDX_W'(id_fold(head.id, BODY_CNT, FOLD_SPLIT - 1, 0));
    assign hv_we    = (state_reg == ST_MUL_D) && work_reg.dyn;
    assign vis_we   = clearing || hv_we;
    assign vis_addr = clearing ? clr_cnt_reg : idx_reg;
    assign dt_s     = $signed({1'b0, time_step});

    assign ctl.take     = take;
    assign ctl.clearing = clearing;
    assign empty        = !res_valid_reg;
    assign result       = res_reg;

    // body state memories, read at item start, written after the half-step velocity
    always_ff @(posedge clk)
    begin
        if (hv_we)
        begin
            hv_mem[idx_reg] <= {hv_reg[2], hv_reg[1], hv_reg[0]};
        end
        if (vis_we)
        begin
            vis_mem[vis_addr] <= !clearing;
        end
        if (take)
        begin
            hv_rd_reg  <= hv_mem[idx_in];
            vis_rd_reg <= vis_mem[idx_in];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            np[i] = work_reg.dyn
                  ? sat_fix(SUM_W'($signed(work_reg.pos[i])) + SUM_W'(rnd_reg[i]))
                  : fix_t'(work_reg.pos[i]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && pop)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_MUL_K;
                end
            end
            ST_MUL_K: state_next = ST_RND_K;
            ST_RND_K: state_next = ST_VEL;
            ST_VEL:   state_next = ST_HALF;
            ST_HALF:  state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_RND_D;
            ST_RND_D: state_next = ST_POS;
            ST_POS:
            begin
                if (!res_hold)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // per-axis datapath, one multiply or one add a step
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    work_reg <= head;
                    idx_reg  <= idx_in;
                end
            end
            ST_MUL_K:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[i] <= $signed(work_reg.acc[i]) * dt_s;
                end
            end
            ST_RND_K:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rnd_reg[i] <= round_shift(prod_reg[i], KICK_SH);
                end
            end
            ST_VEL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nv_reg[i] <= (work_reg.dyn && vis_rd_reg)
                               ? sat_fix(SUM_W'($signed(hv_rd_reg[i*FIX_W +: FIX_W]))
                                         + SUM_W'(rnd_reg[i]))
                               : fix_t'(work_reg.vel[i]);
                end
            end
            ST_HALF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    hv_reg[i] <= sat_fix(SUM_W'(nv_reg[i]) + SUM_W'(rnd_reg[i]));
                end
            end
            ST_MUL_D:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[i] <= hv_reg[i] * dt_s;
                end
            end
            ST_RND_D:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rnd_reg[i] <= round_shift(prod_reg[i], DRIFT_SH);
                end
            end
            ST_POS:
            begin
                if (!res_hold)
                begin
                    res_reg.new_vel_x <= nv_reg[0];
                    res_reg.new_vel_y <= nv_reg[1];
                    res_reg.new_vel_z <= nv_reg[2];
                    res_reg.new_pos_x <= np[0];
                    res_reg.new_pos_y <= np[1];
                    res_reg.new_pos_z <= np[2];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ design/leapfrog_position_integrator_unit.sv @@
// leapfrog_position_integrator_unit: top level of the kick-drift position integrator
// instantiates lpi_front and lpi_back, holds the time step register; depends on lpi_pkg
//
// channel | dir | handshake     | payload
// --------+-----+---------------+------------------------------------
// body    | in  | push / full   | in_item_t, one body per item
// result  | out | pop / empty   | out_item_t, one result per item
// config  | in  | cfg_we        | cfg_wdata, time step dt (Q0.24)
//
// in the back-end sequencer every item passes through state read, kick multiply, round,
// velocity, half-step velocity, drift multiply, round and position; the three axes share
// each step, and a new item is taken only once the last one has left the position step
// the front queue holds two items, so pushes continue while the back end works
// after reset, full stays high while the visited flags of all min(MAX_BODIES, 1024) entries
// are swept clear; time step writes are taken during the sweep
// a finished result waits in the result register; the back end stalls at its last step
// only when that register is still occupied

module leapfrog_position_integrator_unit
    import lpi_pkg::*;
#(
    parameter int MAX_BODIES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    // body items
    input  logic            push,
    output logic            full,
    input  in_item_t        body,
    // result items
    output logic            empty,
    input  logic            pop,
    output out_item_t       result,
    // time step register
    input  logic            cfg_we,
    input  logic [DT_W-1:0] cfg_wdata
);

    logic [DT_W-1:0] time_step_reg;
    bk_ctl_t         ctl;
    logic            head_valid;
    work_t           head;

    // dt register; the user must write it only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= DT_RESET;
        end
        else if (cfg_we)
        begin
            time_step_reg <= cfg_wdata;
        end
    end

    // front end: intake, id reduction, queue
    lpi_front #(
        .MAX_BODIES (MAX_BODIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .body       (body),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head       (head)
    );

    // back end: state memories, integration sequence, result register
    lpi_back #(
        .MAX_BODIES (MAX_BODIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .time_step  (time_step_reg),
        .head_valid (head_valid),
        .head       (head),
        .ctl        (ctl),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

@@ design/lpi_checker.sv @@
// lpi_checker: port-level assertions for the integrator top level, with its bind
// depends on lpi_pkg and leapfrog_position_integrator_unit

module lpi_checker
    import lpi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    // no intake and no result once reset has been seen at a clock edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> (full && empty))
        else $error("full or empty wrong during reset");

    // the visited-flag sweep still blocks intake as reset is released
    a_sweep_blocks: assert property (@(posedge clk) $rose(rst_n) |-> full)
        else $error("item intake open before flag sweep");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result dropped");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("waiting result changed");

endmodule

bind leapfrog_position_integrator_unit lpi_checker u_lpi_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

@@ dv/lpi_result_checker.sv @@
// lpi_result_checker: watches the body, result and time step channels of the
// leapfrog integrator, predicts each result and compares it field by field; uses lpi_pkg
`timescale 1ns / 1ps

module lpi_result_checker
    import lpi_pkg::*;
#(
    parameter int BODIES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            full,
    input  in_item_t        body,
    input  logic            empty,
    input  logic            pop,
    input  out_item_t       result,
    input  logic            cfg_we,
    input  logic [DT_W-1:0] cfg_wdata,
    output int unsigned     pending,
    output int unsigned     checked,
    output int unsigned     mismatches
);

    logic [DT_W-1:0] dt_q;
    fix_t            half_vel_store [BODIES][3];
    bit              unvisited [BODIES];
    out_item_t       expected_motion [$];
    string           field_names [6] = '{"new_vel_x", "new_vel_y", "new_vel_z",
                                         "new_pos_x", "new_pos_y", "new_pos_z"};

    // nearest, ties toward plus infinity (arithmetic shift floors)
    function automatic longint round_half_up(input longint p, input int unsigned sh);
        return (p + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic fix_t clamp32(input longint v);
        if (v > longint'(32'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -longint'(64'sh80000000)) begin
            return 32'sh80000000;
        end
        return fix_t'(v[31:0]);
    endfunction

    // kick-drift step for one body, updates the half-step table
    function automatic out_item_t integrate_body(input in_item_t b);
        fix_t      vel [3];
        fix_t      acc [3];
        fix_t      pos [3];
        fix_t      nv [3];
        fix_t      np [3];
        fix_t      hv [3];
        longint    kick;
        longint    step_dt;
        int        slot;
        out_item_t r;
        vel = '{b.vel_x, b.vel_y, b.vel_z};
        acc = '{b.acc_x, b.acc_y, b.acc_z};
        pos = '{b.pos_x, b.pos_y, b.pos_z};
        nv = vel;
        np = pos;
        step_dt = longint'(dt_q);
        slot = int'(b.body_id) % BODIES;
        if (b.is_dynamic) begin
            for (int i = 0; i < 3; i++) begin
                kick = round_half_up(longint'(acc[i]) * step_dt, KICK_SH);
                if (!unvisited[slot]) begin
                    nv[i] = clamp32(longint'(half_vel_store[slot][i]) + kick);
                end
                hv[i] = clamp32(longint'(nv[i]) + kick);
                np[i] = clamp32(longint'(pos[i])
                                + round_half_up(longint'(hv[i]) * step_dt, DRIFT_SH));
                half_vel_store[slot][i] = hv[i];
            end
            unvisited[slot] = 1'b0;
        end
        r.new_vel_x = nv[0];
        r.new_vel_y = nv[1];
        r.new_vel_z = nv[2];
        r.new_pos_x = np[0];
        r.new_pos_y = np[1];
        r.new_pos_z = np[2];
        return r;
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        fix_t      g [6];
        fix_t      w [6];
        if (expected_motion.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t: result with nothing expected: %h", $realtime, got);
            end
            return;
        end
        want = expected_motion.pop_front();
        checked++;
        g = '{got.new_vel_x, got.new_vel_y, got.new_vel_z,
              got.new_pos_x, got.new_pos_y, got.new_pos_z};
        w = '{want.new_vel_x, want.new_vel_y, want.new_vel_z,
              want.new_pos_x, want.new_pos_y, want.new_pos_z};
        for (int f = 0; f < 6; f++) begin
            if (g[f] !== w[f]) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%t: result %0d %s expected %h got %h", $realtime, checked,
                             field_names[f], w[f], g[f]);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dt_q = DT_RESET;
            expected_motion.delete();
            for (int k = 0; k < BODIES; k++) begin
                unvisited[k] = 1'b1;
                half_vel_store[k] = '{default: '0};
            end
            pending = 0;
            checked = 0;
            mismatches = 0;
        end else begin
            if (cfg_we) begin
                dt_q = cfg_wdata;
            end
            if (pop && !empty) begin
                check_result(result);
            end
            if (push && !full) begin
                expected_motion.push_back(integrate_body(body));
            end
            pending = expected_motion.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// tb_top: stimulus and verdict for leapfrog_position_integrator_unit
// depends on lpi_pkg, the design and dv/lpi_result_checker.sv
`timescale 1ns / 1ps

module tb_top;
    import lpi_pkg::*;

    localparam fix_t FIX_MAX = 32'sh7FFFFFFF;
    localparam fix_t FIX_MIN = 32'sh80000000;
    localparam fix_t HALF_LSB_KICK = 32'sh01000000;   // 2^24, half of one kick lsb at dt = 1
    localparam fix_t HALF_LSB_DRIFT = 32'sh00800000;  // 2^23, same for the drift
    localparam int   PHASE_ITEMS = 234;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            push = 1'b0;
    logic            full;
    in_item_t        body = '0;
    logic            empty;
    logic            pop = 1'b0;
    out_item_t       result;
    logic            cfg_we = 1'b0;
    logic [DT_W-1:0] cfg_wdata = '0;

    int unsigned pending;
    int unsigned checked;
    int unsigned mismatches;

    // steady phases run both sides flat out, no gaps and no stalls
    bit          steady = 1'b1;
    int unsigned pop_hold = 0;
    int unsigned items_sent = 0;
    int unsigned dynamic_sent = 0;
    int unsigned dt_writes = 0;

    always #10 clk = ~clk;

    leapfrog_position_integrator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .body     (body),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    lpi_result_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .body      (body),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pending   (pending),
        .checked   (checked),
        .mismatches(mismatches)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    // field values: extremes, small magnitudes and full-range noise
    function automatic fix_t rand_fix();
        case ($urandom_range(0, 9))
            0: return FIX_MIN;
            1: return FIX_MAX;
            2, 3, 4: return fix_t'($signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000);
            default: return fix_t'($urandom);
        endcase
    endfunction

    function automatic in_item_t body_item(input logic [ID_W-1:0] id, input logic dyn,
                                           input fix_t vx, vy, vz, ax, ay, az, px, py, pz);
        in_item_t b;
        b.body_id = id;
        b.is_dynamic = dyn;
        b.vel_x = vx;
        b.vel_y = vy;
        b.vel_z = vz;
        b.acc_x = ax;
        b.acc_y = ay;
        b.acc_z = az;
        b.pos_x = px;
        b.pos_y = py;
        b.pos_z = pz;
        return b;
    endfunction

    // most ids come from a small pool so that bodies are revisited often,
    // which is the only way to reach the stored half-step velocity path
    function automatic in_item_t rand_body();
        logic [ID_W-1:0] id;
        id = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 15))
                                        : ID_W'($urandom_range(0, 1023));
        return body_item(id, $urandom_range(0, 9) != 0,
                         rand_fix(), rand_fix(), rand_fix(),
                         rand_fix(), rand_fix(), rand_fix(),
                         rand_fix(), rand_fix(), rand_fix());
    endfunction

    // result side: pop held high, with random stall stretches outside steady phases
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold != 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop <= 1'b1;
            pop_hold <= pick_gap();
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_body(input in_item_t b);
        int unsigned gap;
        body <= b;
        push <= 1'b1;
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
        items_sent++;
        if (b.is_dynamic) begin
            dynamic_sent++;
        end
        gap = pick_gap();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // dt may only change once every result in flight has come back;
    // the count is read away from the edge where the checker updates it
    task automatic set_time_step(input logic [DT_W-1:0] v);
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
        @(posedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        dt_writes++;
    endtask

    initial begin
        logic [DT_W-1:0] phase_dt [6];
        phase_dt[0] = DT_RESET;
        phase_dt[1] = 24'hFFFFFF;
        phase_dt[2] = DT_W'($urandom_range(1, 24'hFFFFFE));
        phase_dt[3] = 24'd1;
        phase_dt[4] = DT_W'($urandom_range(2, 4095));
        phase_dt[5] = DT_W'($urandom_range(0, 24'hFFFFFF));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // largest dt so the extremes drive the sums into saturation;
        // written while the block is still sweeping its visited flags
        set_time_step(24'hFFFFFF);

        // pass-through bodies at the id extremes
        send_body(body_item(10'd1023, 1'b0, FIX_MAX, FIX_MAX, FIX_MAX,
                            FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
        send_body(body_item(10'd0, 1'b0, FIX_MIN, FIX_MIN, FIX_MIN,
                            FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
        // first visit then a revisit, saturating high
        send_body(body_item(10'd5, 1'b1, FIX_MAX, FIX_MAX, FIX_MAX,
                            FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
        send_body(body_item(10'd5, 1'b1, 0, 0, 0, FIX_MAX, FIX_MAX, FIX_MAX, 0, 0, 0));
        // same for the low rail
        send_body(body_item(10'd6, 1'b1, FIX_MIN, FIX_MIN, FIX_MIN,
                            FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
        send_body(body_item(10'd6, 1'b1, FIX_MAX, FIX_MAX, FIX_MAX,
                            FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
        send_body(body_item(10'd6, 1'b1, 0, 0, 0, FIX_MAX, FIX_MAX, FIX_MAX, 0, 0, 0));
        // top id, zero motion, then a revisit
        send_body(body_item(10'd1023, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_body(body_item(10'd1023, 1'b1, rand_fix(), rand_fix(), rand_fix(),
                            rand_fix(), rand_fix(), rand_fix(), 0, 0, 0));
        // a static item must not disturb the stored state of body 5
        send_body(body_item(10'd5, 1'b0, rand_fix(), rand_fix(), rand_fix(),
                            rand_fix(), rand_fix(), rand_fix(),
                            rand_fix(), rand_fix(), rand_fix()));
        send_body(body_item(10'd5, 1'b1, rand_fix(), rand_fix(), rand_fix(),
                            32'sh00010000, -32'sh00010000, 0,
                            rand_fix(), rand_fix(), rand_fix()));
        send_body(body_item(10'h2AA, 1'b1, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
                            32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
                            32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA));

        // dt of one lsb: kick and drift land exactly on half an lsb,
        // positive ties round up, negative ties toward zero
        push <= 1'b0;
        set_time_step(24'd1);
        send_body(body_item(10'd100, 1'b1, 0, 0, 0,
                            HALF_LSB_KICK, -HALF_LSB_KICK, 3 * HALF_LSB_KICK, 0, 0, 0));
        send_body(body_item(10'd100, 1'b1, 0, 0, 0, -3 * HALF_LSB_KICK,
                            HALF_LSB_KICK - 1, -HALF_LSB_KICK - 1, 0, 0, 0));
        send_body(body_item(10'd101, 1'b1, HALF_LSB_DRIFT, -HALF_LSB_DRIFT,
                            3 * HALF_LSB_DRIFT, 0, 0, 0, 0, 0, 0));
        send_body(body_item(10'd101, 1'b1, 0, 0, 0, 0, 0, 0, FIX_MAX, FIX_MIN, 0));

        // dt of zero: nothing moves, revisits still return the stored velocity
        push <= 1'b0;
        set_time_step(24'd0);
        send_body(body_item(10'd200, 1'b1, rand_fix(), rand_fix(), rand_fix(),
                            rand_fix(), rand_fix(), rand_fix(),
                            rand_fix(), rand_fix(), rand_fix()));
        send_body(body_item(10'd200, 1'b1, rand_fix(), rand_fix(), rand_fix(),
                            rand_fix(), rand_fix(), rand_fix(),
                            rand_fix(), rand_fix(), rand_fix()));

        // random phases, one dt each; the first runs without any idling
        for (int p = 0; p < 6; p++) begin
            push <= 1'b0;
            set_time_step(phase_dt[p]);
            steady = (p == 0) || ($urandom_range(0, 4) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_body(rand_body());
            end
            steady = 1'b0;
        end
        push <= 1'b0;

        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
        // keep running so that any stray result would still show up
        repeat (20) @(posedge clk);

        $display("covered %0d bodies (%0d integrated, %0d passed through) over %0d dt settings",
                 items_sent, dynamic_sent, items_sent - dynamic_sent, dt_writes);
        $display("%0d results compared, %0d field mismatches, %0d still outstanding",
                 checked, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("leapfrog_position_integrator_unit regression: pass");
        end else begin
            $display("leapfrog_position_integrator_unit regression: fail");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("leapfrog_position_integrator_unit regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
design/lpi_pkg.sv
design/lpi_front.sv
design/lpi_back.sv
design/leapfrog_position_integrator_unit.sv
design/lpi_checker.sv
dv/lpi_result_checker.sv
dv/tb_top.sv
